// ===== hdl/i2cm_pkg.sv =====
// ---------------------------------------------------------------------------
// i2cm_pkg: shared types and constants of the I2C register transfer engine
// Holds the request codes, the phase enum and the queue entry type.
// ---------------------------------------------------------------------------
`default_nettype none
package i2cm_pkg;

	localparam int BufDepthDefault = 16;
	localparam int QueueDepth      = 2;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_LOAD  = 2'd1,
		REQ_START = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_RESP  = 2'd1,
		ST_BROKEN   = 2'd2,
		ST_RESERVED = 2'd3
	} stat_code_t;

	typedef enum logic [1:0] {
		KIND_CHIP_W = 2'd0,
		KIND_REG    = 2'd1,
		KIND_DATA   = 2'd2,
		KIND_CHIP_R = 2'd3
	} kind_t;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'd0,
		PH_START    = 5'd1,
		PH_WB_LOW   = 5'd2,
		PH_WB_HIGH  = 5'd3,
		PH_ACK_LOW  = 5'd4,
		PH_ACK_HIGH = 5'd5,
		PH_ACK_WAIT = 5'd6,
		PH_RB_LOW   = 5'd7,
		PH_RB_HIGH  = 5'd8,
		PH_RB_WAIT  = 5'd9,
		PH_RA_LOW   = 5'd10,
		PH_RA_HIGH  = 5'd11,
		PH_RA_WAIT  = 5'd12,
		PH_RS_A     = 5'd13,
		PH_RS_B     = 5'd14,
		PH_RS_C     = 5'd15,
		PH_RS_D     = 5'd16,
		PH_STOP_A   = 5'd17,
		PH_STOP_B   = 5'd18,
		PH_STOP_C   = 5'd19
	} phase_t;

	// request as held between front and back
	typedef struct packed {
		req_t        req;
		logic [6:0]  chip_addr;
		logic [31:0] reg_addr;
		logic [2:0]  addr_bytes;
		logic [4:0]  byte_count;
		logic        read_not_write;
		logic [7:0]  load_byte;
		logic        scl_in;
		logic        sda_in;
	} entry_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
	} result_t;

endpackage
`default_nettype wire

// ===== hdl/i2cm_if.sv =====
// ---------------------------------------------------------------------------
// i2cm_req_if / i2cm_res_if: valid/ready channels of the engine
// Request channel carries the input fields, result channel the outputs.
// ---------------------------------------------------------------------------
`default_nettype none
interface i2cm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [6:0]  chip_addr;
	logic [31:0] reg_addr;
	logic [2:0]  addr_bytes;
	logic [4:0]  byte_count;
	logic        read_not_write;
	logic [7:0]  load_byte;
	logic        scl_in;
	logic        sda_in;
	modport source (output valid, req_type, chip_addr, reg_addr, addr_bytes, byte_count,
		read_not_write, load_byte, scl_in, sda_in, input ready);
	modport sink (input valid, req_type, chip_addr, reg_addr, addr_bytes, byte_count,
		read_not_write, load_byte, scl_in, sda_in, output ready);
endinterface

interface i2cm_res_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic [7:0] read_byte;
	logic       read_valid;
	logic       busy_res;
	logic       done_res;
	logic [1:0] status;
	modport source (output valid, scl_out, sda_out, read_byte, read_valid, busy_res,
		done_res, status, input ready);
	modport sink (input valid, scl_out, sda_out, read_byte, read_valid, busy_res,
		done_res, status, output ready);
endinterface
`default_nettype wire

// ===== hdl/i2c_master_register_transfer.sv =====
// ---------------------------------------------------------------------------
// i2c_master_register_transfer: I2C master register read/write engine
// Front intake, request queue and bus sequencer with a registered result.
// ---------------------------------------------------------------------------
// Each request (tick, load byte, start) yields one result; the engine takes
// one request per clock while the queue has room. An accepted request leaves
// the queue when the sequencer steps; its result is then registered and held
// until taken. The sequencer updates its state in one step per request, so
// the sustained rate is one request per cycle while the result side
// keeps taking results; the two-entry queue and the output register let
// either side stall alone.
`default_nettype none
module i2c_master_register_transfer #(
	parameter int BUF_DEPTH = i2cm_pkg::BufDepthDefault
) (
	input wire          clk,
	input wire          arst_n,
	i2cm_req_if.sink    req,
	i2cm_res_if.source  res
);
	logic             q_push, q_full, q_pop, q_empty;
	i2cm_pkg::entry_t q_in, q_out;

	i2cm_front u_front (.req(req), .q_full(q_full), .q_push(q_push), .q_data(q_in));

	i2cm_queue #(.DEPTH(i2cm_pkg::QueueDepth)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_data(q_in), .full(q_full),
		.pop(q_pop), .pop_data(q_out), .empty(q_empty));

	i2cm_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_data(q_out), .q_pop(q_pop),
		.res(res));
endmodule
`default_nettype wire

// ===== hdl/i2cm_queue.sv =====
// ---------------------------------------------------------------------------
// i2cm_queue: request queue between front and back
// Small FIFO of decoded requests, registered entries, one push (unless full) and one pop (unless empty) a cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module i2cm_queue #(
	parameter int DEPTH = i2cm_pkg::QueueDepth
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  i2cm_pkg::entry_t       push_data,
	output logic                   full,
	input  wire                    pop,
	output i2cm_pkg::entry_t       pop_data,
	output logic                   empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	i2cm_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      cnt_q;

	assign full     = (cnt_q == (AW+1)'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= push_data;
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop && !empty)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
		end
	end
endmodule
`default_nettype wire

// ===== hdl/i2cm_front.sv =====
// ---------------------------------------------------------------------------
// i2cm_front: request intake
// Classifies each request and masks fields the request type does not use.
// ---------------------------------------------------------------------------
`default_nettype none
module i2cm_front (
	i2cm_req_if.sink          req,
	input  wire               q_full,
	output logic              q_push,
	output i2cm_pkg::entry_t  q_data
);
	assign req.ready = !q_full;
	assign q_push    = req.valid && !q_full;

	// unused fields are zeroed so the back sees clean entries
	always_comb begin
		q_data = '0;
		q_data.req = i2cm_pkg::req_t'(req.req_type);
		unique case (i2cm_pkg::req_t'(req.req_type))
			i2cm_pkg::REQ_TICK: begin
				q_data.scl_in = req.scl_in;
				q_data.sda_in = req.sda_in;
			end
			i2cm_pkg::REQ_LOAD: q_data.load_byte = req.load_byte;
			i2cm_pkg::REQ_START: begin
				q_data.chip_addr      = req.chip_addr;
				q_data.reg_addr       = req.reg_addr;
				q_data.addr_bytes     = req.addr_bytes;
				q_data.byte_count     = req.byte_count;
				q_data.read_not_write = req.read_not_write;
			end
			default: q_data.req = i2cm_pkg::REQ_NONE;
		endcase
	end
endmodule
`default_nettype wire

// ===== hdl/i2cm_back.sv =====
// ---------------------------------------------------------------------------
// i2cm_back: bus engine
// Runs the phase sequencer one request a cycle unless the queue is empty or the result stalls; registers the result.
// ---------------------------------------------------------------------------
`default_nettype none
module i2cm_back #(
	parameter int BUF_DEPTH = i2cm_pkg::BufDepthDefault
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               q_empty,
	input  i2cm_pkg::entry_t  q_data,
	output logic              q_pop,
	i2cm_res_if.source        res
);
	localparam int BW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam logic [8:0] DEPTH9 = 9'(BUF_DEPTH);

	// state
	i2cm_pkg::phase_t phase_q, phase_d;
	i2cm_pkg::kind_t  kind_q, kind_d;
	logic [3:0]  bitc_q, bitc_d;
	logic [7:0]  shift_q, shift_d;
	logic [8:0]  lptr_q, lptr_d;
	logic [4:0]  bidx_q, bidx_d;
	logic [31:0] raddr_q, raddr_d;
	logic [2:0]  aleft_q, aleft_d;
	logic [6:0]  chip_q, chip_d;
	logic        dir_q, dir_d;
	logic [4:0]  cnt_q, cnt_d;
	logic [1:0]  stat_q, stat_d;
	logic        scl_q, scl_d, sda_q, sda_d;
	logic [7:0]  buf_q [BUF_DEPTH];

	logic        out_valid_q;
	i2cm_pkg::result_t out_q, out_d;
	logic        step;
	logic        buf_we;
	logic [8:0]  rd_addr;
	logic [7:0]  buf_rd_q;

	assign step  = !q_empty && (!out_valid_q || res.ready);
	assign q_pop = step;
	assign buf_we = step && q_data.req == i2cm_pkg::REQ_LOAD &&
		phase_q == i2cm_pkg::PH_IDLE && lptr_q < DEPTH9;
	// byte the next data send will need: current index, or the one after a data byte
	assign rd_addr = 9'(bidx_q) + ((kind_q == i2cm_pkg::KIND_DATA) ? 9'd1 : 9'd0);

	// write buffer; the read is registered ahead of use, the index is stable long before an ack
	always_ff @(posedge clk) begin
		if (buf_we) buf_q[lptr_q[BW-1:0]] <= q_data.load_byte;
		if (rd_addr < DEPTH9) buf_rd_q <= buf_q[rd_addr[BW-1:0]];
		else buf_rd_q <= 8'h00;
	end

	// next state: a tick may run on into a follow-on pass, unrolled as flat cases
	always_comb begin
		logic       again;
		logic       nack;
		logic [3:0] bc;
		logic [7:0] sh;
		logic [4:0] bi;
		phase_d = phase_q; kind_d = kind_q; bitc_d = bitc_q; shift_d = shift_q;
		lptr_d = lptr_q; bidx_d = bidx_q; raddr_d = raddr_q; aleft_d = aleft_q;
		chip_d = chip_q; dir_d = dir_q; cnt_d = cnt_q; stat_d = stat_q;
		scl_d = scl_q; sda_d = sda_q;
		out_d = '0;
		again = 1'b0; nack = 1'b0; bc = '0; sh = '0; bi = '0;
		unique case (q_data.req)
			i2cm_pkg::REQ_LOAD: if (buf_we) lptr_d = lptr_q + 9'd1;
			i2cm_pkg::REQ_START: if (phase_q == i2cm_pkg::PH_IDLE) begin
				chip_d  = q_data.chip_addr;
				raddr_d = q_data.reg_addr;
				aleft_d = (q_data.addr_bytes > 3'd4) ? 3'd4 : q_data.addr_bytes;
				dir_d   = q_data.read_not_write;
				cnt_d   = (!q_data.read_not_write && 9'(q_data.byte_count) > DEPTH9) ?
					DEPTH9[4:0] : q_data.byte_count;
				bidx_d = '0; bitc_d = '0; shift_d = '0; lptr_d = '0;
				stat_d = i2cm_pkg::ST_NO_RESP;
				phase_d = i2cm_pkg::PH_START;
			end
			i2cm_pkg::REQ_TICK: begin
				unique case (phase_q)
					i2cm_pkg::PH_START: begin
						scl_d = 1'b1; sda_d = 1'b0;
						shift_d = {chip_q, 1'b0}; bitc_d = '0;
						kind_d = i2cm_pkg::KIND_CHIP_W; phase_d = i2cm_pkg::PH_WB_LOW;
					end
					i2cm_pkg::PH_WB_LOW: begin
						scl_d = 1'b0; sda_d = shift_q[7]; phase_d = i2cm_pkg::PH_WB_HIGH;
					end
					i2cm_pkg::PH_WB_HIGH: begin
						scl_d = 1'b1; sda_d = shift_q[7];
						shift_d = {shift_q[6:0], 1'b0};
						bitc_d = bitc_q + 4'd1;
						phase_d = (bitc_q + 4'd1 >= 4'd8) ? i2cm_pkg::PH_ACK_LOW :
							i2cm_pkg::PH_WB_LOW;
					end
					i2cm_pkg::PH_ACK_LOW: begin
						scl_d = 1'b0; sda_d = 1'b1; phase_d = i2cm_pkg::PH_ACK_HIGH;
					end
					i2cm_pkg::PH_ACK_HIGH: begin
						scl_d = 1'b1; sda_d = 1'b1; phase_d = i2cm_pkg::PH_ACK_WAIT;
					end
					i2cm_pkg::PH_ACK_WAIT: begin
						if (!q_data.scl_in) begin
							scl_d = 1'b1; sda_d = 1'b1;
						end else begin
							nack = q_data.sda_in;
							again = 1'b1;
						end
					end
					i2cm_pkg::PH_RB_LOW: begin
						scl_d = 1'b0; sda_d = 1'b1; phase_d = i2cm_pkg::PH_RB_HIGH;
					end
					i2cm_pkg::PH_RB_HIGH: begin
						scl_d = 1'b1; sda_d = 1'b1; phase_d = i2cm_pkg::PH_RB_WAIT;
					end
					i2cm_pkg::PH_RB_WAIT: begin
						if (!q_data.scl_in) begin
							scl_d = 1'b1; sda_d = 1'b1;
						end else begin
							sh = {shift_q[6:0], q_data.sda_in};
							bc = bitc_q + 4'd1;
							shift_d = sh; bitc_d = bc;
							if (bc >= 4'd8) begin
								out_d.read_byte = sh; out_d.read_valid = 1'b1;
								// acknowledge low half follows in the same tick
								scl_d = 1'b0;
								sda_d = (5'(bidx_q + 5'd1) >= cnt_q);
								phase_d = i2cm_pkg::PH_RA_HIGH;
							end else begin
								scl_d = 1'b0; sda_d = 1'b1;
								phase_d = i2cm_pkg::PH_RB_HIGH;
							end
						end
					end
					i2cm_pkg::PH_RA_LOW: begin
						scl_d = 1'b0; sda_d = (5'(bidx_q + 5'd1) >= cnt_q);
						phase_d = i2cm_pkg::PH_RA_HIGH;
					end
					i2cm_pkg::PH_RA_HIGH: begin
						scl_d = 1'b1; sda_d = (5'(bidx_q + 5'd1) >= cnt_q);
						phase_d = i2cm_pkg::PH_RA_WAIT;
					end
					i2cm_pkg::PH_RA_WAIT: begin
						if (!q_data.scl_in) begin
							scl_d = 1'b1;
						end else begin
							bi = bidx_q + 5'd1;
							bidx_d = bi;
							if (bi < cnt_q) begin
								bitc_d = '0; shift_d = '0;
								scl_d = 1'b0; sda_d = 1'b1;
								phase_d = i2cm_pkg::PH_RB_HIGH;
							end else begin
								stat_d = i2cm_pkg::ST_OK;
								scl_d = 1'b0; sda_d = 1'b0;
								phase_d = i2cm_pkg::PH_STOP_B;
							end
						end
					end
					i2cm_pkg::PH_RS_A: begin
						scl_d = 1'b0; phase_d = i2cm_pkg::PH_RS_B;
					end
					i2cm_pkg::PH_RS_B: begin
						scl_d = 1'b0; sda_d = 1'b1; phase_d = i2cm_pkg::PH_RS_C;
					end
					i2cm_pkg::PH_RS_C: begin
						scl_d = 1'b1; sda_d = 1'b1; phase_d = i2cm_pkg::PH_RS_D;
					end
					i2cm_pkg::PH_RS_D: begin
						scl_d = 1'b1; sda_d = 1'b0;
						shift_d = {chip_q, 1'b1}; bitc_d = '0;
						kind_d = i2cm_pkg::KIND_CHIP_R; phase_d = i2cm_pkg::PH_WB_LOW;
					end
					i2cm_pkg::PH_STOP_A: begin
						scl_d = 1'b0; sda_d = 1'b0; phase_d = i2cm_pkg::PH_STOP_B;
					end
					i2cm_pkg::PH_STOP_B: begin
						scl_d = 1'b1; sda_d = 1'b0; phase_d = i2cm_pkg::PH_STOP_C;
					end
					i2cm_pkg::PH_STOP_C: begin
						scl_d = 1'b1; sda_d = 1'b1; out_d.done_res = 1'b1;
						phase_d = i2cm_pkg::PH_IDLE;
					end
					default: begin
						scl_d = 1'b1; sda_d = 1'b1; phase_d = i2cm_pkg::PH_IDLE;
					end
				endcase
				// after an acknowledge: pick the next byte, then run its first half
				if (again) begin
					logic       dstage;
					logic       send;
					logic       fin;
					logic       rs;
					logic [7:0] val;
					logic [2:0] al;
					logic [4:0] bx;
					dstage = 1'b0; send = 1'b0; fin = 1'b0; rs = 1'b0;
					val = '0; al = aleft_q; bx = bidx_q;
					if (nack) begin
						scl_d = 1'b0; sda_d = 1'b0; phase_d = i2cm_pkg::PH_STOP_B;
					end else begin
						case (kind_q)
							i2cm_pkg::KIND_CHIP_W: stat_d = i2cm_pkg::ST_BROKEN;
							i2cm_pkg::KIND_REG: if (al != 3'd0) al = al - 3'd1;
							i2cm_pkg::KIND_DATA: bx = bidx_q + 5'd1;
							default: ;
						endcase
						aleft_d = al; bidx_d = bx;
						if (kind_q == i2cm_pkg::KIND_CHIP_R) begin
							if (cnt_q == 5'd0) fin = 1'b1;
							else begin
								bitc_d = '0; shift_d = '0;
								scl_d = 1'b0; sda_d = 1'b1;
								phase_d = i2cm_pkg::PH_RB_HIGH;
							end
						end else if (kind_q != i2cm_pkg::KIND_DATA && al != 3'd0) begin
							send = 1'b1; kind_d = i2cm_pkg::KIND_REG;
							val = raddr_q[8*(al-3'd1) +: 8];
						end else begin
							dstage = 1'b1;
						end
						if (dstage) begin
							if (dir_q) rs = 1'b1;
							else if (bx < cnt_q && 9'(bx) < DEPTH9) begin
								send = 1'b1; kind_d = i2cm_pkg::KIND_DATA;
								val = buf_rd_q;
							end else fin = 1'b1;
						end
						if (fin) begin
							stat_d = i2cm_pkg::ST_OK;
							scl_d = 1'b0; sda_d = 1'b0; phase_d = i2cm_pkg::PH_STOP_B;
						end
						if (rs) begin
							scl_d = 1'b0; phase_d = i2cm_pkg::PH_RS_B;
						end
						if (send) begin
							bitc_d = '0; shift_d = val;
							scl_d = 1'b0; sda_d = val[7];
							phase_d = i2cm_pkg::PH_WB_HIGH;
						end
					end
				end
			end
			default: ;
		endcase
		out_d.scl_out  = scl_d;
		out_d.sda_out  = sda_d;
		out_d.busy_res = (phase_d != i2cm_pkg::PH_IDLE);
		out_d.status   = stat_d;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cm_pkg::PH_IDLE; kind_q <= i2cm_pkg::KIND_CHIP_W;
			bitc_q <= '0; shift_q <= '0; lptr_q <= '0; bidx_q <= '0;
			raddr_q <= '0; aleft_q <= '0; chip_q <= '0; dir_q <= 1'b0;
			cnt_q <= '0; stat_q <= '0; scl_q <= 1'b1; sda_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q <= phase_d; kind_q <= kind_d; bitc_q <= bitc_d;
				shift_q <= shift_d; lptr_q <= lptr_d; bidx_q <= bidx_d;
				raddr_q <= raddr_d; aleft_q <= aleft_d; chip_q <= chip_d;
				dir_q <= dir_d; cnt_q <= cnt_d; stat_q <= stat_d;
				scl_q <= scl_d; sda_q <= sda_d;
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (step) out_q <= out_d;
	end

	assign res.valid      = out_valid_q;
	assign res.scl_out    = out_q.scl_out;
	assign res.sda_out    = out_q.sda_out;
	assign res.read_byte  = out_q.read_byte;
	assign res.read_valid = out_q.read_valid;
	assign res.busy_res   = out_q.busy_res;
	assign res.done_res   = out_q.done_res;
	assign res.status     = out_q.status;
endmodule
`default_nettype wire

// ===== hdl/i2cm_checker.sv =====
// ---------------------------------------------------------------------------
// i2cm_checker: port level checks of the engine
// Watches the result channel for consistent transfer status.
// ---------------------------------------------------------------------------
`default_nettype none
module i2cm_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       res_valid,
	input wire       res_ready,
	input wire       read_valid,
	input wire [7:0] read_byte,
	input wire       done_res,
	input wire       busy_res,
	input wire [1:0] status,
	input wire       scl_out
);
	// a finished transfer is no longer busy
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> !busy_res) else $error("done while busy");
	// a received byte only during a transfer
	a_rd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && read_valid |-> busy_res) else $error("read outside transfer");
	// read_byte is zero unless flagged
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !read_valid |-> read_byte == 8'h00) else $error("stray read data");
	// the reserved status code never shows
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> status != 2'd3) else $error("bad status");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(scl_out) && $stable(status))
		else $error("result dropped");
endmodule

bind i2c_master_register_transfer i2cm_checker u_checker (
	.clk(clk), .arst_n(arst_n), .res_valid(res.valid), .res_ready(res.ready),
	.read_valid(res.read_valid), .read_byte(res.read_byte), .done_res(res.done_res),
	.busy_res(res.busy_res), .status(res.status), .scl_out(res.scl_out));
`default_nettype wire

// ===== dv/i2cm_tb_if.sv =====
// ---------------------------------------------------------------------------
// i2cm_tb_if: testbench side types of the engine channels
// Holds the request record the testbench offers on the request channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
// The channel interfaces live in the RTL tree; this file only gathers the
// testbench's own helper types kept apart from the top module.
package i2cm_tb_pkg;

	// one request as offered on the request channel
	typedef struct packed {
		i2cm_pkg::req_t req;
		logic [6:0]     chip;
		logic [31:0]    raddr;
		logic [2:0]     nabytes;
		logic [4:0]     cnt;
		logic           rnw;
		logic [7:0]     data;
		logic           scl;
		logic           sda;
	} bus_req_t;
endpackage

// ===== dv/i2c_master_register_transfer_tb.sv =====
// ---------------------------------------------------------------------------
// i2c_master_register_transfer_tb: self-checking bench of the I2C engine
// Drives loads, starts and bus ticks from a modeled slave, predicts every
// result in a scoreboard and compares all result fields in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module i2c_master_register_transfer_tb;

	localparam int BufDepth   = i2cm_pkg::BufDepthDefault;
	localparam int StallLimit = 5000;
	localparam int ItemTarget = 1650;

	// scoreboard: engine predictor plus queue of expected results
	class i2c_engine_sb;
		i2cm_pkg::phase_t  ph;
		i2cm_pkg::kind_t   kind;
		logic [3:0]        nbit;
		logic [7:0]        shreg;
		logic [7:0]        wbuf [BufDepth];
		int                lptr, bidx, aleft, hcount;
		logic [31:0]       hraddr;
		logic [6:0]        hchip;
		logic              hdir;
		logic [1:0]        rstat;
		logic              dscl, dsda;
		i2cm_pkg::result_t pending[$];
		int                errors, mismatches, n_in;

		function new();
			ph = i2cm_pkg::PH_IDLE; kind = i2cm_pkg::KIND_CHIP_W; nbit = 0; shreg = 0;
			lptr = 0; bidx = 0; aleft = 0; hcount = 0; hraddr = 0; hchip = 0;
			hdir = 0; rstat = i2cm_pkg::ST_OK; dscl = 1; dsda = 1;
			errors = 0; mismatches = 0; n_in = 0;
			foreach (wbuf[i]) wbuf[i] = 0;
		endfunction

		function void load_shift(logic [7:0] v, i2cm_pkg::kind_t k);
			shreg = v; nbit = 0; kind = k; ph = i2cm_pkg::PH_WB_LOW;
		endfunction

		function void to_stop(logic [1:0] code);
			rstat = code; ph = i2cm_pkg::PH_STOP_A;
		endfunction

		function void data_step();
			if (hdir) ph = i2cm_pkg::PH_RS_A;
			else if (bidx < hcount && bidx < BufDepth)
				load_shift(wbuf[bidx], i2cm_pkg::KIND_DATA);
			else to_stop(i2cm_pkg::ST_OK);
		endfunction

		function void addr_step();
			if (aleft > 0) load_shift(8'(hraddr >> (8 * (aleft - 1))), i2cm_pkg::KIND_REG);
			else data_step();
		endfunction

		function void begin_read();
			nbit = 0; shreg = 0; ph = i2cm_pkg::PH_RB_LOW;
		endfunction

		function void acked(logic nack);
			if (nack) begin
				ph = i2cm_pkg::PH_STOP_A;
				return;
			end
			case (kind)
				i2cm_pkg::KIND_CHIP_W: begin rstat = i2cm_pkg::ST_BROKEN; addr_step(); end
				i2cm_pkg::KIND_REG: begin if (aleft > 0) aleft--; addr_step(); end
				i2cm_pkg::KIND_DATA: begin bidx = (bidx + 1) & 31; data_step(); end
				default: if (hcount == 0) to_stop(i2cm_pkg::ST_OK); else begin_read();
			endcase
		endfunction

		function void bus_tick(logic scl, logic sda, output logic [7:0] rd,
				output logic rv, output logic dn);
			logic again;
			logic ab;
			rd = 0; rv = 0; dn = 0;
			for (int p = 0; p < 3; p++) begin
				again = 0;
				case (ph)
					i2cm_pkg::PH_START: begin
						dscl = 1; dsda = 0; load_shift({hchip, 1'b0}, i2cm_pkg::KIND_CHIP_W);
					end
					i2cm_pkg::PH_WB_LOW: begin
						dscl = 0; dsda = shreg[7]; ph = i2cm_pkg::PH_WB_HIGH;
					end
					i2cm_pkg::PH_WB_HIGH: begin
						dscl = 1; dsda = shreg[7]; shreg = shreg << 1; nbit++;
						ph = (nbit >= 8) ? i2cm_pkg::PH_ACK_LOW : i2cm_pkg::PH_WB_LOW;
					end
					i2cm_pkg::PH_ACK_LOW: begin dscl = 0; dsda = 1; ph = i2cm_pkg::PH_ACK_HIGH; end
					i2cm_pkg::PH_ACK_HIGH: begin dscl = 1; dsda = 1; ph = i2cm_pkg::PH_ACK_WAIT; end
					i2cm_pkg::PH_ACK_WAIT: if (!scl) begin dscl = 1; dsda = 1; end
						else begin acked(sda); again = 1; end
					i2cm_pkg::PH_RB_LOW: begin dscl = 0; dsda = 1; ph = i2cm_pkg::PH_RB_HIGH; end
					i2cm_pkg::PH_RB_HIGH: begin dscl = 1; dsda = 1; ph = i2cm_pkg::PH_RB_WAIT; end
					i2cm_pkg::PH_RB_WAIT: if (!scl) begin dscl = 1; dsda = 1; end
						else begin
							shreg = {shreg[6:0], sda}; nbit++;
							if (nbit >= 8) begin
								rd = shreg; rv = 1; ph = i2cm_pkg::PH_RA_LOW;
							end else ph = i2cm_pkg::PH_RB_LOW;
							again = 1;
						end
					i2cm_pkg::PH_RA_LOW, i2cm_pkg::PH_RA_HIGH: begin
						ab = (bidx + 1 >= hcount);
						if (ph == i2cm_pkg::PH_RA_LOW) begin
							dscl = 0; dsda = ab; ph = i2cm_pkg::PH_RA_HIGH;
						end else begin
							dscl = 1; dsda = ab; ph = i2cm_pkg::PH_RA_WAIT;
						end
					end
					i2cm_pkg::PH_RA_WAIT: if (!scl) dscl = 1;
						else begin
							bidx = (bidx + 1) & 31;
							if (bidx < hcount) begin_read(); else to_stop(i2cm_pkg::ST_OK);
							again = 1;
						end
					i2cm_pkg::PH_RS_A: begin dscl = 0; ph = i2cm_pkg::PH_RS_B; end
					i2cm_pkg::PH_RS_B: begin dscl = 0; dsda = 1; ph = i2cm_pkg::PH_RS_C; end
					i2cm_pkg::PH_RS_C: begin dscl = 1; dsda = 1; ph = i2cm_pkg::PH_RS_D; end
					i2cm_pkg::PH_RS_D: begin
						dscl = 1; dsda = 0; load_shift({hchip, 1'b1}, i2cm_pkg::KIND_CHIP_R);
					end
					i2cm_pkg::PH_STOP_A: begin dscl = 0; dsda = 0; ph = i2cm_pkg::PH_STOP_B; end
					i2cm_pkg::PH_STOP_B: begin dscl = 1; dsda = 0; ph = i2cm_pkg::PH_STOP_C; end
					i2cm_pkg::PH_STOP_C: begin
						dscl = 1; dsda = 1; dn = 1; ph = i2cm_pkg::PH_IDLE;
					end
					default: begin dscl = 1; dsda = 1; ph = i2cm_pkg::PH_IDLE; end
				endcase
				if (!again) break;
			end
		endfunction

		// note an accepted request and queue its expected result
		function void note_request(i2cm_tb_pkg::bus_req_t r);
			i2cm_pkg::result_t e;
			logic [7:0] rd;
			logic rv, dn;
			rd = 0; rv = 0; dn = 0;
			n_in++;
			case (r.req)
				i2cm_pkg::REQ_TICK: bus_tick(r.scl, r.sda, rd, rv, dn);
				i2cm_pkg::REQ_LOAD: if (ph == i2cm_pkg::PH_IDLE && lptr < BufDepth) begin
					wbuf[lptr] = r.data; lptr++;
				end
				i2cm_pkg::REQ_START: if (ph == i2cm_pkg::PH_IDLE) begin
					hchip = r.chip; hraddr = r.raddr;
					aleft = (r.nabytes > 4) ? 4 : r.nabytes;
					hdir = r.rnw;
					hcount = (!r.rnw && r.cnt > BufDepth) ? BufDepth : r.cnt;
					bidx = 0; nbit = 0; shreg = 0; lptr = 0; rstat = i2cm_pkg::ST_NO_RESP;
					ph = i2cm_pkg::PH_START;
				end
				default: ;
			endcase
			e.scl_out = dscl; e.sda_out = dsda; e.read_byte = rd; e.read_valid = rv;
			e.busy_res = (ph != i2cm_pkg::PH_IDLE); e.done_res = dn; e.status = rstat;
			pending.push_back(e);
		endfunction

		// compare one accepted result with the oldest expectation
		function void check_result(i2cm_pkg::result_t got);
			i2cm_pkg::result_t e;
			if (pending.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result %p", got);
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result mismatch exp %p got %p", e, got);
			end
		endfunction
	endclass

	logic clk, arst_n;
	i2cm_req_if req ();
	i2cm_res_if res ();

	i2c_master_register_transfer #(.BUF_DEPTH(BufDepth)) dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .res(res.source));

	i2c_engine_sb sb;
	int idle_pct;        // percent of idle cycles on each side
	bit hold_off;        // long receiver stall requested
	int quiet = 0;

	// slave model knobs: NACK and clock stretch rates
	int nack_pct, stretch_pct;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// result side: random ready with one long hold-off
	initial begin
		res.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				res.ready <= 0;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			res.ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		i2cm_pkg::result_t got;
		if (arst_n && res.valid && res.ready) begin
			got.scl_out = res.scl_out; got.sda_out = res.sda_out;
			got.read_byte = res.read_byte; got.read_valid = res.read_valid;
			got.busy_res = res.busy_res; got.done_res = res.done_res;
			got.status = res.status;
			sb.check_result(got);
		end
	end

	// watchdog on progress
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (res.valid && res.ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= StallLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// offer one request, wait for acceptance, note it
	task automatic send(i2cm_tb_pkg::bus_req_t r);
		while ($urandom_range(99) < idle_pct) begin
			req.valid <= 0;
			@(posedge clk);
		end
		req.valid <= 1; req.req_type <= r.req; req.chip_addr <= r.chip;
		req.reg_addr <= r.raddr; req.addr_bytes <= r.nabytes; req.byte_count <= r.cnt;
		req.read_not_write <= r.rnw; req.load_byte <= r.data;
		req.scl_in <= r.scl; req.sda_in <= r.sda;
		do @(posedge clk); while (!req.ready);
		sb.note_request(r);
	endtask

	function automatic i2cm_tb_pkg::bus_req_t rand_fields();
		i2cm_tb_pkg::bus_req_t r;
		r.req = i2cm_pkg::REQ_TICK; r.chip = 7'($urandom); r.raddr = $urandom;
		r.nabytes = 3'($urandom); r.cnt = 5'($urandom); r.rnw = 1'($urandom);
		r.data = 8'($urandom); r.scl = 1'($urandom); r.sda = 1'($urandom);
		return r;
	endfunction

	task automatic do_load(logic [7:0] v);
		i2cm_tb_pkg::bus_req_t r;
		r = rand_fields(); r.req = i2cm_pkg::REQ_LOAD; r.data = v;
		send(r);
	endtask

	// tick with slave response computed from the predicted phase
	task automatic do_tick();
		i2cm_tb_pkg::bus_req_t r;
		r = rand_fields();
		r.scl = 1;
		r.sda = sb.dsda;
		case (sb.ph)
			i2cm_pkg::PH_ACK_WAIT: begin
				if ($urandom_range(99) < stretch_pct) r.scl = 0;
				r.sda = ($urandom_range(99) < nack_pct);
			end
			i2cm_pkg::PH_RB_WAIT: begin
				if ($urandom_range(99) < stretch_pct) r.scl = 0;
				r.sda = 1'($urandom);
			end
			i2cm_pkg::PH_RA_WAIT: if ($urandom_range(99) < stretch_pct) r.scl = 0;
			default: ;
		endcase
		send(r);
	endtask

	// whole transfer: loads, start, ticks (with stray requests mixed in) until done
	task automatic transfer(logic rnw, int cnt, int nab, int nloads);
		i2cm_tb_pkg::bus_req_t r;
		int guard;
		for (int i = 0; i < nloads; i++) do_load(8'($urandom));
		r = rand_fields(); r.req = i2cm_pkg::REQ_START; r.rnw = rnw;
		r.cnt = 5'(cnt); r.nabytes = 3'(nab);
		send(r);
		guard = 0;
		while (sb.ph != i2cm_pkg::PH_IDLE && guard < 2000) begin
			if ($urandom_range(99) < 3) begin
				r = rand_fields();
				r.req = i2cm_pkg::req_t'(2'($urandom_range(1, 3)));
				send(r);
			end else do_tick();
			guard++;
		end
	endtask

	initial begin
		i2cm_tb_pkg::bus_req_t r;
		int n;
		sb = new();
		idle_pct = 0; hold_off = 0;
		nack_pct = 0; stretch_pct = 0;
		arst_n = 0;
		req.valid = 0; req.req_type = i2cm_pkg::REQ_TICK; req.chip_addr = 0;
		req.reg_addr = 0; req.addr_bytes = 0; req.byte_count = 0; req.read_not_write = 0;
		req.load_byte = 0; req.scl_in = 1; req.sda_in = 1;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed, no idling: idle tick, unknown request, full buffer, long write
		r = rand_fields(); send(r);
		r.req = i2cm_pkg::REQ_NONE; send(r);
		for (int i = 0; i < BufDepth; i++) do_load(i == 0 ? 8'h00 : 8'hFF);
		do_load(8'hA5); // buffer full, ignored
		transfer(0, 31, 7, 0);   // write above buffer, too many address bytes

		// from here both sides idle at random; results held off once
		idle_pct = 26;
		hold_off = 1;
		transfer(1, 0, 0, 0);    // read of zero bytes
		transfer(1, 31, 4, 0);   // long read, last byte NACKed
		nack_pct = 100;
		transfer(0, 0, 1, 1);    // address NACK: not responding
		nack_pct = 0;

		// random transfers up to the item budget
		while (sb.n_in < ItemTarget) begin
			stretch_pct = $urandom_range(0, 30);
			nack_pct = ($urandom_range(9) == 0) ? 30 : 2;
			if ($urandom_range(1)) begin
				transfer(1, $urandom_range(0, 3), $urandom_range(0, 4), 0);
			end else begin
				n = $urandom_range(1, 4);
				transfer(0, n, $urandom_range(0, 4), n);
			end
		end

		// drain
		req.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
